>>> sv/two_list_round_robin_scheduler_top_assert.svh
// Assertion macros for the scheduler RTL.
// Included by tlrr_dp, the module that carries the concurrent checks; no other dependencies.
`ifndef TWO_LIST_ROUND_ROBIN_SCHEDULER_TOP_ASSERT_SVH
`define TWO_LIST_ROUND_ROBIN_SCHEDULER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TLRR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler assertion failed");

// Next-cycle implication, disabled during reset.
`define TLRR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler assertion failed");

`endif

>>> sv/tlrr_pkg.sv
// Package for the two-list round-robin scheduler: sizes, action codes and
// the command and status structures between controller and datapath.
package tlrr_pkg;

   // Sizes of the task tables and queues.
   localparam int MAX_TASKS  = 16;
   localparam int TASK_W     = 4;
   localparam int CNT_W      = 5;
   localparam int PRI_W      = 8;
   localparam int SLICE_BITS = 8;
   localparam int ACTION_W   = 2;

   // Action codes carried by an input beat.
   localparam logic [ACTION_W-1:0] ACT_YIELD = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SET   = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic add;          // store priority and flag, queue the task if new
      logic set_flag;     // store the runnable flag only
      logic yield_start;  // count the slice down, holding at zero
      logic move;         // blocked head of active queue to other tail
      logic swap;         // exchange the roles of the queues
      logic pick;         // schedule the active head and issue it
      logic emit_cur;     // issue the current task again
      logic emit_none;    // issue the nothing-runnable result
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic keep_cur;     // slice left and current task runnable
      logic act_empty;    // active queue holds no task
      logic head_run;     // active queue head is runnable
      logic out_free;     // result register can take a beat
   } dp_status_type;

endpackage

>>> sv/two_list_round_robin_scheduler_top.sv
// Two-list round-robin scheduler. Add and set-status beats give no result. A
// yield whose current task keeps running issues that task again once the result
// register is free; otherwise the queue scan moves one task per cycle. One beat
// is worked on at a time. Reset is synchronous and clears queues, flags and
// slice; queue slots themselves are not cleared.
module two_list_round_robin_scheduler_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [tlrr_pkg::ACTION_W-1:0]   req_action,
   input  logic [tlrr_pkg::TASK_W-1:0]     req_task_number,
   input  logic [tlrr_pkg::PRI_W-1:0]      req_priority_req,
   input  logic                            req_runnable,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [tlrr_pkg::TASK_W-1:0]     rsp_run_task,
   output logic                            rsp_none_runnable
);

   tlrr_pkg::dp_cmd_type    cmd;
   tlrr_pkg::dp_status_type status;

   // Sequencer.
   tlrr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .status     (status),
      .cmd        (cmd)
   );

   // Queues, tables and result register.
   tlrr_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_task_number   (req_task_number),
      .req_priority_req  (req_priority_req),
      .req_runnable      (req_runnable),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_run_task      (rsp_run_task),
      .rsp_none_runnable (rsp_none_runnable)
   );

endmodule

>>> sv/tlrr_dp.sv
// Datapath of the scheduler: the two task queues, task tables, slice counter
// and result register. Depends on tlrr_pkg and the assertion macro header.
`include "two_list_round_robin_scheduler_top_assert.svh"

module tlrr_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  tlrr_pkg::dp_cmd_type           cmd,
   output tlrr_pkg::dp_status_type        status,
   input  logic [tlrr_pkg::TASK_W-1:0]    req_task_number,
   input  logic [tlrr_pkg::PRI_W-1:0]     req_priority_req,
   input  logic                           req_runnable,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output logic [tlrr_pkg::TASK_W-1:0]    rsp_run_task,
   output logic                           rsp_none_runnable
);

   // Queue storage; entries are only read within the live count.
   logic [tlrr_pkg::TASK_W-1:0] qa_mem_ff [tlrr_pkg::MAX_TASKS];
   logic [tlrr_pkg::TASK_W-1:0] qb_mem_ff [tlrr_pkg::MAX_TASKS];

   logic [1:0][tlrr_pkg::TASK_W-1:0] head_ff, head_in;
   logic [1:0][tlrr_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                             active_ff, active_in;
   logic [tlrr_pkg::SLICE_BITS-1:0]  slice_ff, slice_in;
   logic                             cur_valid_ff, cur_valid_in;
   logic [tlrr_pkg::TASK_W-1:0]      cur_task_ff, cur_task_in;
   logic [tlrr_pkg::MAX_TASKS-1:0]   runnable_ff, runnable_in;
   logic [tlrr_pkg::MAX_TASKS-1:0]   in_queue_ff, in_queue_in;
   logic [tlrr_pkg::PRI_W-1:0]       pri_ff [tlrr_pkg::MAX_TASKS];
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [tlrr_pkg::TASK_W-1:0]      rsp_task_ff, rsp_task_in;
   logic                             rsp_none_ff, rsp_none_in;

   logic                             other_q;
   logic [tlrr_pkg::TASK_W-1:0]      head_task;
   logic [tlrr_pkg::TASK_W-1:0]      tail_addr;
   logic                             do_move;
   logic                             add_new;
   logic                             wr_a, wr_b;
   logic [tlrr_pkg::TASK_W-1:0]      wr_a_addr, wr_b_addr;
   logic [tlrr_pkg::TASK_W-1:0]      wr_a_data, wr_b_data;
   logic                             out_free;

   // Head of the active queue and the tail slot of the other queue.
   assign other_q   = ~active_ff;
   assign head_task = active_ff ? qb_mem_ff[head_ff[1]] : qa_mem_ff[head_ff[0]];
   assign tail_addr = head_ff[other_q] + count_ff[other_q][tlrr_pkg::TASK_W-1:0];
   assign do_move   = cmd.move | cmd.pick;
   assign add_new   = cmd.add & ~in_queue_ff[req_task_number];
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   // Queue write ports: a new task enters at the head of the first queue,
   // a moved task at the tail of the other queue.
   always_comb begin
      wr_a      = 1'b0;
      wr_b      = 1'b0;
      wr_a_addr = tail_addr;
      wr_b_addr = tail_addr;
      wr_a_data = head_task;
      wr_b_data = head_task;
      if (add_new) begin
         wr_a      = 1'b1;
         wr_a_addr = head_ff[0] - 1'b1;
         wr_a_data = req_task_number;
      end else if (do_move) begin
         wr_a = ~other_q;
         wr_b = other_q;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_a) begin
         qa_mem_ff[wr_a_addr] <= wr_a_data;
      end
      if (wr_b) begin
         qb_mem_ff[wr_b_addr] <= wr_b_data;
      end
   end

   // Queue pointers and roles.
   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      active_in = active_ff ^ cmd.swap;
      if (add_new) begin
         head_in[0]  = head_ff[0] - 1'b1;
         count_in[0] = count_ff[0] + 1'b1;
      end else if (do_move) begin
         head_in[active_ff]  = head_ff[active_ff] + 1'b1;
         count_in[active_ff] = count_ff[active_ff] - 1'b1;
         count_in[other_q]   = count_ff[other_q] + 1'b1;
      end
   end

   // Task tables, slice and current task.
   always_comb begin
      runnable_in  = runnable_ff;
      in_queue_in  = in_queue_ff;
      slice_in     = slice_ff;
      cur_valid_in = cur_valid_ff;
      cur_task_in  = cur_task_ff;
      if (cmd.add || cmd.set_flag) begin
         runnable_in[req_task_number] = req_runnable;
      end
      if (cmd.add) begin
         in_queue_in[req_task_number] = 1'b1;
      end
      if (cmd.yield_start && slice_ff != '0) begin
         slice_in = slice_ff - 1'b1;
      end
      if (cmd.pick) begin
         slice_in     = pri_ff[head_task][tlrr_pkg::SLICE_BITS-1:0];
         cur_task_in  = head_task;
         cur_valid_in = 1'b1;
      end
      if (cmd.emit_none) begin
         cur_valid_in = 1'b0;
      end
   end

   // Result register: loaded by the controller only when it is free.
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_task_in  = rsp_task_ff;
      rsp_none_in  = rsp_none_ff;
      if (cmd.emit_cur) begin
         rsp_valid_in = 1'b1;
         rsp_task_in  = cur_task_ff;
         rsp_none_in  = 1'b0;
      end else if (cmd.pick) begin
         rsp_valid_in = 1'b1;
         rsp_task_in  = head_task;
         rsp_none_in  = 1'b0;
      end else if (cmd.emit_none) begin
         rsp_valid_in = 1'b1;
         rsp_task_in  = '0;
         rsp_none_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         active_ff    <= 1'b0;
         slice_ff     <= '0;
         cur_valid_ff <= 1'b0;
         cur_task_ff  <= '0;
         runnable_ff  <= '0;
         in_queue_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < tlrr_pkg::MAX_TASKS; i++) begin
            pri_ff[i] <= '0;
         end
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         active_ff    <= active_in;
         slice_ff     <= slice_in;
         cur_valid_ff <= cur_valid_in;
         cur_task_ff  <= cur_task_in;
         runnable_ff  <= runnable_in;
         in_queue_ff  <= in_queue_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.add) begin
            pri_ff[req_task_number] <= req_priority_req;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_task_ff <= rsp_task_in;
      rsp_none_ff <= rsp_none_in;
   end

   // Status back to the controller.
   assign status.keep_cur  = (slice_ff != '0) && cur_valid_ff && runnable_ff[cur_task_ff];
   assign status.act_empty = (count_ff[active_ff] == '0);
   assign status.head_run  = runnable_ff[head_task];
   assign status.out_free  = out_free;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_run_task      = rsp_task_ff;
   assign rsp_none_runnable = rsp_none_ff;

   // Every queued task sits in exactly one queue slot.
   `TLRR_ASSERT_IMPL(a_population, clock, reset, 1'b1, ($countones(in_queue_ff) == ({1'b0, count_ff[0]} + {1'b0, count_ff[1]})))
   // A task is never taken from an empty active queue.
   `TLRR_ASSERT_IMPL(a_move_nonempty, clock, reset, do_move, !status.act_empty)
   // A result is only written into a free result register.
   `TLRR_ASSERT_IMPL(a_emit_free, clock, reset, (cmd.pick || cmd.emit_cur || cmd.emit_none), out_free)
   // A scheduled task is issued in the following cycle.
   `TLRR_ASSERT_NEXT(a_pick_issue, clock, reset, cmd.pick, (rsp_valid_ff && !rsp_none_ff && cur_valid_ff))

endmodule

>>> sv/tlrr_ctrl.sv
// Controller of the scheduler: sequences each yield beat through slice check,
// queue scans and task selection. Depends on tlrr_pkg.
module tlrr_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [tlrr_pkg::ACTION_W-1:0]   req_action,
   input  tlrr_pkg::dp_status_type         status,
   output tlrr_pkg::dp_cmd_type            cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_SCAN1 = 5'b00100,
      ST_SCAN2 = 5'b01000,
      ST_PICK  = 5'b10000
   } tlrr_state_type;

   tlrr_state_type state_ff, state_in;
   logic           accept;

   // Input beats are taken only between yields.
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & (state_ff == ST_IDLE);

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  tlrr_pkg::ACT_YIELD: begin
                     cmd.yield_start = 1'b1;
                     state_in        = ST_CHECK;
                  end
                  tlrr_pkg::ACT_ADD: begin
                     cmd.add = 1'b1;
                  end
                  tlrr_pkg::ACT_SET: begin
                     cmd.set_flag = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CHECK: begin
            if (status.keep_cur) begin
               if (status.out_free) begin
                  cmd.emit_cur = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               state_in = ST_SCAN1;
            end
         end
         ST_SCAN1: begin
            if (status.act_empty) begin
               cmd.swap = 1'b1;
               state_in = ST_SCAN2;
            end else if (status.head_run) begin
               state_in = ST_PICK;
            end else begin
               cmd.move = 1'b1;
            end
         end
         ST_SCAN2: begin
            if (status.act_empty) begin
               if (status.out_free) begin
                  cmd.emit_none = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else if (status.head_run) begin
               state_in = ST_PICK;
            end else begin
               cmd.move = 1'b1;
            end
         end
         ST_PICK: begin
            if (status.out_free) begin
               cmd.pick = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> tb/sv/two_list_round_robin_scheduler_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the two-list round-robin scheduler: it drives add, set,
// yield and ignored beats, tracks the queues, slice and flags in its own scheduler and
// compares every result beat. Depends on tlrr_pkg and two_list_round_robin_scheduler_top.
module two_list_round_robin_scheduler_top_tb;

   // The action code that the block ignores.
   localparam logic [tlrr_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 2 * tlrr_pkg::MAX_TASKS + 30;

   typedef struct packed {
      logic [tlrr_pkg::ACTION_W-1:0] action;
      logic [tlrr_pkg::TASK_W-1:0]   task_number;
      logic [tlrr_pkg::PRI_W-1:0]    priority_req;
      logic                          runnable;
   } sched_cmd_type;

   typedef struct packed {
      logic [tlrr_pkg::TASK_W-1:0] run_task;
      logic                        none_runnable;
   } sched_grant_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [tlrr_pkg::ACTION_W-1:0] req_action = tlrr_pkg::ACT_YIELD;
   logic [tlrr_pkg::TASK_W-1:0]   req_task_number = '0;
   logic [tlrr_pkg::PRI_W-1:0]    req_priority_req = '0;
   logic                          req_runnable = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [tlrr_pkg::TASK_W-1:0]   rsp_run_task;
   logic                          rsp_none_runnable;

   two_list_round_robin_scheduler_top uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_task_number   (req_task_number),
      .req_priority_req  (req_priority_req),
      .req_runnable      (req_runnable),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_run_task      (rsp_run_task),
      .rsp_none_runnable (rsp_none_runnable)
   );

   // Free-running clock with a period of 2 ns.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Scheduler state as the testbench tracks it.
   logic [tlrr_pkg::TASK_W-1:0]     q_slots [2][tlrr_pkg::MAX_TASKS];
   logic [tlrr_pkg::TASK_W-1:0]     q_head [2];
   logic [tlrr_pkg::CNT_W-1:0]      q_count [2];
   logic                            active_q;
   logic [tlrr_pkg::SLICE_BITS-1:0] slice_left;
   logic                            cur_valid;
   logic [tlrr_pkg::TASK_W-1:0]     cur_task;
   logic                            ready_flag [tlrr_pkg::MAX_TASKS];
   logic [tlrr_pkg::PRI_W-1:0]      task_prio [tlrr_pkg::MAX_TASKS];
   logic                            task_queued [tlrr_pkg::MAX_TASKS];

   sched_cmd_type   pending_cmds[$];
   sched_grant_type expected_grants[$];
   sched_cmd_type   held_cmd;
   sched_grant_type grant;
   sched_grant_type seen;
   sched_grant_type want;
   int              idle_pct = 0;
   int              stall_pct = 0;
   int              fault_count = 0;
   int              cycle_count = 0;

   function automatic void clear_schedule();
      q_head[0] = '0;
      q_head[1] = '0;
      q_count[0] = '0;
      q_count[1] = '0;
      active_q = 1'b0;
      slice_left = '0;
      cur_valid = 1'b0;
      cur_task = '0;
      for (int i = 0; i < tlrr_pkg::MAX_TASKS; i++) begin
         ready_flag[i] = 1'b0;
         task_prio[i] = '0;
         task_queued[i] = 1'b0;
      end
   endfunction

   function automatic logic [tlrr_pkg::TASK_W-1:0] take_head(input logic q);
      logic [tlrr_pkg::TASK_W-1:0] t;
      t = q_slots[q][q_head[q]];
      q_head[q] = q_head[q] + 1'b1;
      q_count[q] = q_count[q] - 1'b1;
      return t;
   endfunction

   function automatic void put_tail(input logic q, input logic [tlrr_pkg::TASK_W-1:0] t);
      logic [tlrr_pkg::TASK_W-1:0] slot;
      slot = q_head[q] + q_count[q][tlrr_pkg::TASK_W-1:0];
      q_slots[q][slot] = t;
      q_count[q] = q_count[q] + 1'b1;
   endfunction

   // Walk the active queue from its head, sending blocked tasks to the other queue.
   function automatic bit scan_active();
      logic [tlrr_pkg::TASK_W-1:0] t;
      while (q_count[active_q] != 0) begin
         t = q_slots[active_q][q_head[active_q]];
         if (ready_flag[t]) return 1'b1;
         void'(take_head(active_q));
         put_tail(!active_q, t);
      end
      return 1'b0;
   endfunction

   // Apply one accepted beat; returns 1 when it yields a grant.
   function automatic bit schedule_beat(input sched_cmd_type c, output sched_grant_type r);
      logic [tlrr_pkg::TASK_W-1:0] t;
      bit found;
      r = '0;
      case (c.action)
         tlrr_pkg::ACT_ADD: begin
            task_prio[c.task_number] = c.priority_req;
            ready_flag[c.task_number] = c.runnable;
            if (!task_queued[c.task_number]) begin
               task_queued[c.task_number] = 1'b1;
               q_head[0] = q_head[0] - 1'b1;
               q_slots[0][q_head[0]] = c.task_number;
               q_count[0] = q_count[0] + 1'b1;
            end
            return 1'b0;
         end
         tlrr_pkg::ACT_SET: begin
            ready_flag[c.task_number] = c.runnable;
            return 1'b0;
         end
         tlrr_pkg::ACT_YIELD: begin
            if (slice_left != 0) slice_left = slice_left - 1'b1;
            if (slice_left != 0 && cur_valid && ready_flag[cur_task]) begin
               r.run_task = cur_task;
               return 1'b1;
            end
            found = scan_active();
            if (q_count[active_q] == 0) active_q = !active_q;
            if (!found) begin
               found = scan_active();
               if (!found) begin
                  cur_valid = 1'b0;
                  r.none_runnable = 1'b1;
                  return 1'b1;
               end
            end
            t = take_head(active_q);
            put_tail(!active_q, t);
            slice_left = task_prio[t][tlrr_pkg::SLICE_BITS-1:0];
            cur_task = t;
            cur_valid = 1'b1;
            r.run_task = t;
            return 1'b1;
         end
         default: begin
            return 1'b0;
         end
      endcase
   endfunction

   function automatic void note_fault(input string what, input sched_grant_type exp_g,
                                      input sched_grant_type got_g);
      if (fault_count < 10)
         $display("%s: expected task %0d none %0b, got task %0d none %0b", what,
                  exp_g.run_task, exp_g.none_runnable, got_g.run_task, got_g.none_runnable);
      fault_count++;
   endfunction

   function automatic void queue_cmd(input logic [tlrr_pkg::ACTION_W-1:0] action,
                                     input int tnum, input int pri, input bit run);
      sched_cmd_type c;
      c.action = action;
      c.task_number = tnum[tlrr_pkg::TASK_W-1:0];
      c.priority_req = pri[tlrr_pkg::PRI_W-1:0];
      c.runnable = run;
      pending_cmds.push_back(c);
   endfunction

   // Random beats; ignored beats do not count towards the target.
   task automatic queue_random_cmds(input int target);
      int made;
      int pick;
      int val;
      int run_bias;
      sched_cmd_type c;
      made = 0;
      run_bias = 50;
      while (made < target) begin
         // Change how often tasks are runnable every so often, so that all-blocked
         // spells and busy spells both occur.
         if (made % 64 == 0) begin
            pick = $urandom_range(2, 0);
            run_bias = (pick == 0) ? 15 : (pick == 1) ? 50 : 85;
         end
         pick = $urandom_range(99, 0);
         if (pick < 50) c.action = tlrr_pkg::ACT_YIELD;
         else if (pick < 78) c.action = tlrr_pkg::ACT_SET;
         else if (pick < 95) c.action = tlrr_pkg::ACT_ADD;
         else c.action = ACT_UNUSED;
         val = $urandom_range(tlrr_pkg::MAX_TASKS - 1, 0);
         c.task_number = val[tlrr_pkg::TASK_W-1:0];
         c.runnable = ($urandom_range(99, 0) < run_bias);
         pick = $urandom_range(99, 0);
         if (pick < 60) val = $urandom_range(3, 0);
         else if (pick < 95) val = $urandom_range(24, 4);
         else val = $urandom_range(255, 0);
         c.priority_req = val[tlrr_pkg::PRI_W-1:0];
         pending_cmds.push_back(c);
         if (c.action != ACT_UNUSED) made++;
      end
   endtask

   // Driver: offers the next pending beat and predicts each beat as it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (schedule_beat(held_cmd, grant)) expected_grants.push_back(grant);
         end
         if (!req_valid || !req_stall) begin
            if (pending_cmds.size() != 0 &&
                !(idle_pct != 0 && $urandom_range(99, 0) < idle_pct)) begin
               held_cmd = pending_cmds.pop_front();
               req_valid <= 1'b1;
               req_action <= held_cmd.action;
               req_task_number <= held_cmd.task_number;
               req_priority_req <= held_cmd.priority_req;
               req_runnable <= held_cmd.runnable;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stalls at random and checks each accepted result beat.
   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99, 0) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.run_task = rsp_run_task;
         seen.none_runnable = rsp_none_runnable;
         if (expected_grants.size() == 0) begin
            note_fault("unexpected result beat", '0, seen);
         end else begin
            want = expected_grants.pop_front();
            if (rsp_run_task !== want.run_task || rsp_none_runnable !== want.none_runnable)
               note_fault("result mismatch", want, seen);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("two_list_round_robin_scheduler_top_tb: done, errors");
         $finish;
      end
   end

   initial begin
      clear_schedule();
      idle_pct = 26;
      stall_pct = 65;

      // Directed opening: empty queues, extreme priorities, re-adding a queued task,
      // the ignored action, a blocked current task and the nothing-runnable case.
      queue_cmd(tlrr_pkg::ACT_YIELD, 0, 0, 1'b0);
      queue_cmd(tlrr_pkg::ACT_ADD, 0, 0, 1'b1);
      queue_cmd(tlrr_pkg::ACT_ADD, 15, 255, 1'b0);
      queue_cmd(tlrr_pkg::ACT_ADD, 5, 1, 1'b1);
      queue_cmd(tlrr_pkg::ACT_YIELD, 0, 0, 1'b0);
      queue_cmd(tlrr_pkg::ACT_YIELD, 0, 0, 1'b0);
      queue_cmd(ACT_UNUSED, 10, 8'hAA, 1'b1);
      queue_cmd(tlrr_pkg::ACT_SET, 15, 0, 1'b1);
      queue_cmd(tlrr_pkg::ACT_ADD, 0, 3, 1'b1);
      queue_cmd(tlrr_pkg::ACT_YIELD, 0, 0, 1'b0);
      queue_cmd(tlrr_pkg::ACT_ADD, 10, 255, 1'b1);
      queue_cmd(tlrr_pkg::ACT_YIELD, 15, 8'h55, 1'b1);
      queue_cmd(tlrr_pkg::ACT_YIELD, 0, 0, 1'b0);
      queue_cmd(tlrr_pkg::ACT_YIELD, 0, 0, 1'b0);
      queue_cmd(tlrr_pkg::ACT_SET, 10, 0, 1'b0);
      queue_cmd(tlrr_pkg::ACT_YIELD, 0, 0, 1'b0);
      queue_cmd(tlrr_pkg::ACT_SET, 0, 0, 1'b0);
      queue_cmd(tlrr_pkg::ACT_SET, 5, 0, 1'b0);
      queue_cmd(tlrr_pkg::ACT_SET, 15, 0, 1'b0);
      queue_cmd(tlrr_pkg::ACT_YIELD, 0, 0, 1'b0);
      queue_cmd(tlrr_pkg::ACT_YIELD, 0, 0, 1'b0);
      queue_cmd(tlrr_pkg::ACT_SET, 15, 0, 1'b1);
      queue_cmd(tlrr_pkg::ACT_YIELD, 0, 0, 1'b0);
      queue_cmd(tlrr_pkg::ACT_YIELD, 0, 0, 1'b0);
      queue_random_cmds(534);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Second phase: the sender idles more than the receiver stalls.
      while (pending_cmds.size() != 0) @(posedge clock);
      @(negedge clock);
      idle_pct = 65;
      stall_pct = 26;
      queue_random_cmds(533);

      // Third phase: both sides at full rate.
      while (pending_cmds.size() != 0) @(posedge clock);
      @(negedge clock);
      idle_pct = 0;
      stall_pct = 0;
      queue_random_cmds(533);

      // Drain, then allow for a late stray beat before the verdict.
      while (pending_cmds.size() != 0 || req_valid || expected_grants.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (expected_grants.size() != 0) begin
         want = expected_grants.pop_front();
         note_fault("missing result beat", want, '0);
      end
      if (fault_count == 0) begin
         $display("two_list_round_robin_scheduler_top_tb: done, clean");
      end else begin
         $display("two_list_round_robin_scheduler_top_tb: done, errors");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+sv
sv/tlrr_pkg.sv
sv/tlrr_dp.sv
sv/tlrr_ctrl.sv
sv/two_list_round_robin_scheduler_top.sv
tb/sv/two_list_round_robin_scheduler_top_tb.sv
